// ===== rtl/assert_macros.svh =====
// assertion helpers used by qau_queue
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/qau_pkg.sv =====
// shared types for the quaternion arithmetic unit
// no dependencies
package qau_pkg;

  // operation codes as carried on the kind port
  typedef enum logic [2:0] {
    KIND_ADD   = 3'd0,
    KIND_SUB   = 3'd1,
    KIND_MUL   = 3'd2,
    KIND_QDIV  = 3'd3,
    KIND_CONJ  = 3'd4,
    KIND_SCALE = 3'd5,
    KIND_SDIV  = 3'd6,
    KIND_NONE  = 3'd7
  } kind_t;

  // classification made by the front end
  typedef struct packed {
    kind_t kind;
    logic  zero_res;   // result forced to zero
    logic  dz;         // zero scalar divisor
  } op_t;

  localparam int OP_BITS = $bits(op_t);

endpackage

// ===== rtl/qau_front.sv =====
// front end: accepts a command and classifies it into an op_t
// depends on qau_pkg
module qau_front #(
  parameter int W = 32
) (
  input  logic                              start,
  input  logic                              full,
  input  logic [2:0]                        kind,
  input  logic [4*W-1:0]                    lhs,
  input  logic [4*W-1:0]                    rhs,
  input  logic [W-1:0]                      scalar,
  output logic                              push,
  output logic [qau_pkg::OP_BITS+9*W-1:0]   entry
);

  qau_pkg::op_t op;
  logic         sdz;

  // accept whenever the queue has room
  assign push = start && !full;

  // decode kind and catch a zero scalar divisor early
  always_comb begin
    op.kind     = qau_pkg::kind_t'(kind);
    sdz         = (op.kind == qau_pkg::KIND_SDIV) && (scalar == '0);
    op.dz       = sdz;
    op.zero_res = sdz || (op.kind == qau_pkg::KIND_NONE);
  end

  assign entry = {op, scalar, rhs, lhs};

endmodule

// ===== rtl/qau_queue.sv =====
// short fifo between front and back end
// depends on assert_macros.svh
`include "assert_macros.svh"

module qau_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic             full
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr, rptr;
  logic [CW-1:0]    count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign dout  = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_IMPLY(q_no_overrun, clk, rst, push && !pop, !full, "push into full queue")
  `ASSERT_IMPLY(q_no_underrun, clk, rst, pop, !empty, "pop from empty queue")
  `ASSERT_NEXT(q_fill_step, clk, rst, push && !pop, count == $past(count) + 1'b1, "fill count lost a transfer")

endmodule

// ===== rtl/qau_div.sv =====
// one lane of the rounding divider: restoring, one quotient bit per stage,
// followed by saturation and sign restore; no dependencies
module qau_div #(
  parameter int W  = 32,
  parameter int RW = 98,
  parameter int DW = 65
) (
  input  logic          clk,
  input  logic [RW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic          neg,
  output logic [W-1:0]  res,
  output logic          ovf
);

  // stage k decides quotient bit W-k
  logic [RW-1:0] in_rem [W+1];
  logic [DW-1:0] in_den [W+1];
  logic          in_neg [W+1];
  logic [W:0]    in_q   [W+1];
  logic [RW-1:0] dsh    [W+1];
  logic          take   [W+1];

  logic [RW-1:0] rem  [W];
  logic [DW-1:0] dd   [W];
  logic          ng   [W+1];
  logic [W:0]    qt   [W+1];

  logic [W-1:0]  limit, v;
  logic          sat;

  // stage inputs and trial subtract
  always_comb begin
    in_rem[0] = num;
    in_den[0] = den;
    in_neg[0] = neg;
    in_q[0]   = '0;
    for (int k = 1; k <= W; k++) begin
      in_rem[k] = rem[k-1];
      in_den[k] = dd[k-1];
      in_neg[k] = ng[k-1];
      in_q[k]   = qt[k-1];
    end
    for (int k = 0; k <= W; k++) begin
      dsh[k]  = RW'(in_den[k]) << (W - k);
      take[k] = (in_rem[k] >= dsh[k]);
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    for (int k = 0; k <= W; k++) begin
      qt[k] <= in_q[k] | ((W+1)'(take[k]) << (W - k));
      ng[k] <= in_neg[k];
      if (k < W) begin
        rem[k] <= take[k] ? in_rem[k] - dsh[k] : in_rem[k];
        dd[k]  <= in_den[k];
      end
    end
  end

  // saturate to the signed word
  always_comb begin
    limit = ng[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    sat   = qt[W][W] || (qt[W][W-1:0] > limit);
    v     = sat ? limit : qt[W][W-1:0];
  end

  always_ff @(posedge clk) begin
    res <= ng[W] ? W'(-v) : v;
    ovf <= sat;
  end

endmodule

// ===== rtl/qau_back.sv =====
// back end: product array, numerator and divisor forming, rounding add and
// four divider lanes; depends on qau_pkg and qau_div
module qau_back #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            valid,
  input  logic [qau_pkg::OP_BITS+9*W-1:0] entry,
  output logic                            done,
  output logic [4*W-1:0]                  res,
  output logic                            overflow,
  output logic                            divide_by_zero
);

  localparam int NW  = 2*W + 2 + F;
  localparam int DW  = 2*W + 1;
  localparam int RWA = NW + 1;
  localparam int RWB = DW + W + 1;
  localparam int RW  = (RWA > RWB) ? RWA : RWB;
  localparam int L   = W + 2;

  qau_pkg::op_t        op_in, op1, op2;
  logic signed [W-1:0] l_in [4], r_in [4], rsel [4];
  logic signed [W-1:0] s_in;

  logic signed [W-1:0]   l1 [4], r1 [4];
  logic signed [W-1:0]   s1;
  logic signed [2*W-1:0] p1 [4][4];
  logic signed [2*W-1:0] sq1 [4];
  logic                  v1, v2, v3, v4;

  logic signed [NW-1:0] h [4], c [4];
  logic signed [NW-1:0] num_n [4], num2 [4];
  logic [DW-1:0]        den_n, den2, den3, den4;

  logic [NW-1:0] mag3 [4];
  logic          neg3 [4], neg4 [4];
  logic          zero3, dz3, zero4, dz4;
  logic [RW-1:0] n4 [4];

  logic          vl [L], zl [L], dl [L];
  logic [W-1:0]  lane_res [4];
  logic          lane_ovf [4];

  // unpack the queue entry
  always_comb begin
    op_in = qau_pkg::op_t'(entry[9*W +: qau_pkg::OP_BITS]);
    s_in  = entry[8*W +: W];
    for (int i = 0; i < 4; i++) begin
      l_in[i] = entry[i*W +: W];
      r_in[i] = entry[(4+i)*W +: W];
      rsel[i] = (op_in.kind == qau_pkg::KIND_SCALE) ? s_in : r_in[i];
    end
  end

  // product array
  always_ff @(posedge clk) begin
    for (int a = 0; a < 4; a++) begin
      for (int b = 0; b < 4; b++) begin
        p1[a][b] <= l_in[a] * rsel[b];
      end
      sq1[a] <= r_in[a] * r_in[a];
      l1[a]  <= l_in[a];
      r1[a]  <= r_in[a];
    end
    s1  <= s_in;
    op1 <= op_in;
  end

  // hamilton sums, plain and with conjugated right operand
  always_comb begin
    h[0] = NW'(p1[0][0]) - NW'(p1[1][1]) - NW'(p1[2][2]) - NW'(p1[3][3]);
    h[1] = NW'(p1[0][1]) + NW'(p1[1][0]) + NW'(p1[2][3]) - NW'(p1[3][2]);
    h[2] = NW'(p1[0][2]) + NW'(p1[2][0]) + NW'(p1[3][1]) - NW'(p1[1][3]);
    h[3] = NW'(p1[0][3]) + NW'(p1[3][0]) + NW'(p1[1][2]) - NW'(p1[2][1]);
    c[0] = NW'(p1[0][0]) + NW'(p1[1][1]) + NW'(p1[2][2]) + NW'(p1[3][3]);
    c[1] = NW'(p1[1][0]) - NW'(p1[0][1]) - NW'(p1[2][3]) + NW'(p1[3][2]);
    c[2] = NW'(p1[2][0]) - NW'(p1[0][2]) - NW'(p1[3][1]) + NW'(p1[1][3]);
    c[3] = NW'(p1[3][0]) - NW'(p1[0][3]) - NW'(p1[1][2]) + NW'(p1[2][1]);
  end

  // numerator and divisor per kind
  always_comb begin
    den_n = DW'(1);
    for (int i = 0; i < 4; i++) begin
      num_n[i] = '0;
    end
    case (op1.kind)
      qau_pkg::KIND_ADD: begin
        for (int i = 0; i < 4; i++) num_n[i] = NW'(l1[i]) + NW'(r1[i]);
      end
      qau_pkg::KIND_SUB: begin
        for (int i = 0; i < 4; i++) num_n[i] = NW'(l1[i]) - NW'(r1[i]);
      end
      qau_pkg::KIND_MUL: begin
        for (int i = 0; i < 4; i++) num_n[i] = h[i];
        den_n = DW'(1) << F;
      end
      qau_pkg::KIND_QDIV: begin
        for (int i = 0; i < 4; i++) num_n[i] = c[i] << F;
        den_n = DW'($unsigned(sq1[0])) + DW'($unsigned(sq1[1]))
              + DW'($unsigned(sq1[2])) + DW'($unsigned(sq1[3]));
      end
      qau_pkg::KIND_CONJ: begin
        num_n[0] = NW'(l1[0]);
        for (int i = 1; i < 4; i++) num_n[i] = -NW'(l1[i]);
      end
      qau_pkg::KIND_SCALE: begin
        for (int i = 0; i < 4; i++) num_n[i] = NW'(p1[i][0]);
        den_n = DW'(1) << F;
      end
      qau_pkg::KIND_SDIV: begin
        for (int i = 0; i < 4; i++) begin
          num_n[i] = s1[W-1] ? -(NW'(l1[i]) << F) : (NW'(l1[i]) << F);
        end
        den_n = s1[W-1] ? DW'($unsigned(-s1)) : DW'($unsigned(s1));
      end
      default: begin
        den_n = DW'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) num2[i] <= num_n[i];
    den2 <= den_n;
    op2  <= op1;
  end

  // sign and magnitude, zero norm check
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      neg3[i] <= num2[i][NW-1];
      mag3[i] <= num2[i][NW-1] ? NW'($unsigned(-num2[i])) : NW'($unsigned(num2[i]));
    end
    den3  <= den2;
    zero3 <= op2.zero_res || ((op2.kind == qau_pkg::KIND_QDIV) && (den2 == '0));
    dz3   <= op2.dz || ((op2.kind == qau_pkg::KIND_QDIV) && (den2 == '0));
  end

  // rounding bias: half the divisor
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      n4[i]   <= RW'(mag3[i]) + RW'(den3 >> 1);
      neg4[i] <= neg3[i];
    end
    den4  <= den3;
    zero4 <= zero3;
    dz4   <= dz3;
  end

  // valid through the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // divider lanes
  for (genvar g = 0; g < 4; g++) begin : g_lane
    qau_div #(.W(W), .RW(RW), .DW(DW)) u_div (
      .clk (clk),
      .num (n4[g]),
      .den (den4),
      .neg (neg4[g]),
      .res (lane_res[g]),
      .ovf (lane_ovf[g])
    );
  end

  // flags ride alongside the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < L; k++) vl[k] <= 1'b0;
    end else begin
      vl[0] <= v4;
      for (int k = 1; k < L; k++) vl[k] <= vl[k-1];
    end
  end

  always_ff @(posedge clk) begin
    zl[0] <= zero4;
    dl[0] <= dz4;
    for (int k = 1; k < L; k++) begin
      zl[k] <= zl[k-1];
      dl[k] <= dl[k-1];
    end
  end

  // result assembly
  always_comb begin
    done           = vl[L-1];
    divide_by_zero = dl[L-1];
    for (int i = 0; i < 4; i++) begin
      res[i*W +: W] = zl[L-1] ? '0 : lane_res[i];
    end
    overflow = !zl[L-1] && (lane_ovf[0] || lane_ovf[1] || lane_ovf[2] || lane_ovf[3]);
  end

endmodule

// ===== rtl/quaternion_arithmetic_unit_core.sv =====
// top level of the quaternion arithmetic unit
// depends on qau_pkg, qau_front, qau_queue, qau_back
//
// One command is accepted per cycle (start high while busy is low) and its
// result appears on the res ports with done high for one cycle; results
// come back in command order. Every kind runs through the same path: a
// product array, a numerator/divisor stage, a rounding add and a divider
// with one quotient bit per stage, which sets the latency. The back end
// never stalls, so the queue between front and back end never fills and
// busy stays low in operation.
module quaternion_arithmetic_unit_core #(
  parameter int WORD_BITS   = 32,
  parameter int FRAC_BITS   = 16,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  kind,
  input  logic signed [WORD_BITS-1:0] lhs_re,
  input  logic signed [WORD_BITS-1:0] lhs_i,
  input  logic signed [WORD_BITS-1:0] lhs_j,
  input  logic signed [WORD_BITS-1:0] lhs_k,
  input  logic signed [WORD_BITS-1:0] rhs_re,
  input  logic signed [WORD_BITS-1:0] rhs_i,
  input  logic signed [WORD_BITS-1:0] rhs_j,
  input  logic signed [WORD_BITS-1:0] rhs_k,
  input  logic signed [WORD_BITS-1:0] scalar,
  output logic                        done,
  output logic signed [WORD_BITS-1:0] res_re,
  output logic signed [WORD_BITS-1:0] res_i,
  output logic signed [WORD_BITS-1:0] res_j,
  output logic signed [WORD_BITS-1:0] res_k,
  output logic                        overflow,
  output logic                        divide_by_zero
);

  localparam int EW = qau_pkg::OP_BITS + 9*WORD_BITS;

  logic          push, pop, empty, full;
  logic [EW-1:0] entry_in, entry_out;
  logic [4*WORD_BITS-1:0] res_all;

  assign busy = full;
  assign pop  = !empty;

  // accept and classify
  qau_front #(.W(WORD_BITS)) u_front (
    .start  (start),
    .full   (full),
    .kind   (kind),
    .lhs    ({lhs_k, lhs_j, lhs_i, lhs_re}),
    .rhs    ({rhs_k, rhs_j, rhs_i, rhs_re}),
    .scalar (scalar),
    .push   (push),
    .entry  (entry_in)
  );

  // decoupling queue
  qau_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (entry_in),
    .pop   (pop),
    .dout  (entry_out),
    .empty (empty),
    .full  (full)
  );

  // arithmetic
  qau_back #(.W(WORD_BITS), .F(FRAC_BITS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .valid          (pop),
    .entry          (entry_out),
    .done           (done),
    .res            (res_all),
    .overflow       (overflow),
    .divide_by_zero (divide_by_zero)
  );

  assign res_re = res_all[0*WORD_BITS +: WORD_BITS];
  assign res_i  = res_all[1*WORD_BITS +: WORD_BITS];
  assign res_j  = res_all[2*WORD_BITS +: WORD_BITS];
  assign res_k  = res_all[3*WORD_BITS +: WORD_BITS];

endmodule
